// ===== hw/rtl/mbp_pkg.sv =====
// shared types and constants for the mirror border padding block
`timescale 1ns / 1ps
package mbp_pkg;

  localparam int DIM_W = 9;
  localparam int RAD_W = 7;
  localparam int COORD_W = 9;
  localparam int CH_W = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;
  localparam int SPAN_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 2'd3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_RADIUS = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

  typedef struct packed {
    logic rd;
    status_t status;
  } meta_t;

endpackage

// ===== hw/rtl/mirror_border_padding_top.sv =====
// top level of the mirror border padding block
// request path: s1, s2, s3 and output registers, frozen while out_valid waits on out_ready
// throughput: one request per cycle unless stalled, loads and reads alike, one single-port store
// a request makes at most one access to the store; loads give no response
// reset clears the write position, the pipeline and the registers to their defaults
// frame store contents are undefined after reset until loaded; there is no clearing pass
`timescale 1ns / 1ps
module mirror_border_padding_top import mbp_pkg::*; #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic                  frame_start,
  input  logic [CH_W-1:0]       pixel_red,
  input  logic [CH_W-1:0]       pixel_green,
  input  logic [CH_W-1:0]       pixel_blue,
  input  logic [COORD_W-1:0]    pad_x,
  input  logic [COORD_W-1:0]    pad_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic [1:0]            read_status
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(DEPTH);

  logic [DIM_W-1:0] img_width, img_height;
  logic [RAD_W-1:0] border_radius;
  logic color_mode;
  logic [DIM_W-1:0] eff_w, eff_h;

  logic adv;
  logic s1_valid, s1_type, s1_frame_start;
  logic [PIX_W-1:0] s1_pixel;
  logic [COORD_W-1:0] s1_pad_x, s1_pad_y;

  mem_ctl_t mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [PIX_W-1:0] mem_wdata, mem_rdata;
  meta_t meta, s3_meta;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign eff_w = (32'(img_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : img_width;
  assign eff_h = (32'(img_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : img_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width <= DIM_W'(256);
      img_height <= DIM_W'(256);
      border_radius <= RAD_W'(1);
      color_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMG_WIDTH: img_width <= cfg_data;
        REG_IMG_HEIGHT: img_height <= cfg_data;
        REG_BORDER_RADIUS: border_radius <= cfg_data[RAD_W-1:0];
        REG_COLOR_MODE: color_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s3_meta <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s3_meta <= meta;
      out_valid <= s3_meta.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_type <= req_type;
      s1_frame_start <= frame_start;
      s1_pixel <= {pixel_blue, pixel_green, pixel_red};
      s1_pad_x <= pad_x;
      s1_pad_y <= pad_y;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      read_status <= s3_meta.status;
      if (s3_meta.status == ST_OK) begin
        out_red <= mem_rdata[CH_W-1:0];
        out_green <= color_mode ? mem_rdata[2*CH_W-1:CH_W] : '0;
        out_blue <= color_mode ? mem_rdata[3*CH_W-1:2*CH_W] : '0;
      end else begin
        out_red <= '0;
        out_green <= '0;
        out_blue <= '0;
      end
    end
  end

  mbp_addr #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS),
    .AW(AW)
  ) u_addr (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .s1_valid(s1_valid),
    .s1_type(s1_type),
    .s1_frame_start(s1_frame_start),
    .s1_pixel(s1_pixel),
    .s1_pad_x(s1_pad_x),
    .s1_pad_y(s1_pad_y),
    .eff_w(eff_w),
    .eff_h(eff_h),
    .radius(border_radius),
    .mem_ctl(mem_ctl),
    .mem_addr(mem_addr),
    .mem_wdata(mem_wdata),
    .meta(meta)
  );

  mbp_store #(
    .AW(AW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk(clk),
    .ctl(mem_ctl),
    .addr(mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

endmodule

// ===== hw/rtl/mbp_store.sv =====
// frame store: single-port synchronous memory with registered read data
`timescale 1ns / 1ps
module mbp_store import mbp_pkg::*; #(
  parameter int AW = 16,
  parameter int DEPTH = 65536
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [AW-1:0]    addr,
  input  logic [PIX_W-1:0] wdata,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hw/rtl/mbp_addr.sv =====
// raster write pointer, reflect-101 coordinate mapping and store addressing
`timescale 1ns / 1ps
module mbp_addr import mbp_pkg::*; #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 64,
  parameter int AW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               s1_valid,
  input  logic               s1_type,
  input  logic               s1_frame_start,
  input  logic [PIX_W-1:0]   s1_pixel,
  input  logic [COORD_W-1:0] s1_pad_x,
  input  logic [COORD_W-1:0] s1_pad_y,
  input  logic [DIM_W-1:0]   eff_w,
  input  logic [DIM_W-1:0]   eff_h,
  input  logic [RAD_W-1:0]   radius,
  output mem_ctl_t           mem_ctl,
  output logic [AW-1:0]      mem_addr,
  output logic [PIX_W-1:0]   mem_wdata,
  output meta_t              meta
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT + 1);

  logic [XW-1:0] col, col_next;
  logic [YW-1:0] row, row_next;

  logic [XW-1:0] col0;
  logic [YW-1:0] row0;
  logic in_frame;
  logic [AW-1:0] waddr;

  logic radius_bad, range_bad;
  logic signed [SPAN_W-1:0] dx, dy;
  logic [SPAN_W-1:0] ax, ay;
  status_t status;

  logic s2_valid, s2_read, s2_wr;
  status_t s2_status;
  logic [SPAN_W-1:0] s2_ax, s2_ay;
  logic [AW-1:0] s2_waddr;
  logic [PIX_W-1:0] s2_wdata;

  logic [SPAN_W-1:0] fx, fy;
  logic [AW-1:0] raddr;

  // write pointer
  always_comb begin
    col0 = s1_frame_start ? '0 : col;
    row0 = s1_frame_start ? '0 : row;
    in_frame = (32'(row0) < 32'(eff_h)) && (32'(col0) < 32'(eff_w));
    waddr = AW'(32'(row0) * MAX_WIDTH + 32'(col0));
    col_next = col;
    row_next = row;
    if (s1_valid && s1_type == REQ_LOAD) begin
      col_next = col0;
      row_next = row0;
      if (in_frame) begin
        if (32'(col0) + 32'd1 >= 32'(eff_w)) begin
          col_next = '0;
          row_next = YW'(32'(row0) + 32'd1);
        end else begin
          col_next = XW'(32'(col0) + 32'd1);
        end
      end
    end
  end

  // status and distance from the border
  always_comb begin
    radius_bad = (32'(radius) > MAX_RADIUS) || ({2'b0, radius} >= eff_w)
                 || ({2'b0, radius} >= eff_h);
    range_bad = ({2'b0, s1_pad_x} >= {2'b0, eff_w} + {3'b0, radius, 1'b0})
                || ({2'b0, s1_pad_y} >= {2'b0, eff_h} + {3'b0, radius, 1'b0});
    if (radius_bad) begin
      status = ST_RADIUS;
    end else if (range_bad) begin
      status = ST_RANGE;
    end else begin
      status = ST_OK;
    end
    dx = signed'({2'b0, s1_pad_x}) - signed'({4'b0, radius});
    dy = signed'({2'b0, s1_pad_y}) - signed'({4'b0, radius});
    ax = dx[SPAN_W-1] ? SPAN_W'(-dx) : SPAN_W'(dx);
    ay = dy[SPAN_W-1] ? SPAN_W'(-dy) : SPAN_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      col <= col_next;
      row <= row_next;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_read <= s1_type;
      s2_wr <= in_frame;
      s2_status <= status;
      s2_ax <= ax;
      s2_ay <= ay;
      s2_waddr <= waddr;
      s2_wdata <= s1_pixel;
    end
  end

  // fold back past the far edge
  always_comb begin
    fx = (s2_ax >= {2'b0, eff_w}) ? ({1'b0, eff_w, 1'b0} - SPAN_W'(2) - s2_ax) : s2_ax;
    fy = (s2_ay >= {2'b0, eff_h}) ? ({1'b0, eff_h, 1'b0} - SPAN_W'(2) - s2_ay) : s2_ay;
    raddr = AW'(32'(fy) * MAX_WIDTH + 32'(fx));
    mem_addr = s2_read ? raddr : s2_waddr;
    mem_wdata = s2_wdata;
    mem_ctl.wr = adv && s2_valid && (s2_read == REQ_LOAD) && s2_wr;
    mem_ctl.rd = adv && s2_valid && (s2_read == REQ_READ) && (s2_status == ST_OK);
    meta.rd = s2_valid && (s2_read == REQ_READ);
    meta.status = s2_status;
  end

endmodule

// ===== hw/rtl/mbp_checker.sv =====
// port-level checks for the mirror border padding block, with its bind
`timescale 1ns / 1ps
module mbp_checker import mbp_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CH_W-1:0] out_red,
  input logic [CH_W-1:0] out_green,
  input logic [CH_W-1:0] out_blue,
  input logic [1:0]      read_status
);

  // no response right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("response valid after reset");

  // stalled response holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_status) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue))
    else $error("stalled response changed");

  // error responses carry zero pixels
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_status != ST_OK |-> out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("error response with nonzero pixel");

  // status code in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> read_status == ST_OK || read_status == ST_RADIUS || read_status == ST_RANGE)
    else $error("undefined read status");

endmodule

bind mirror_border_padding_top mbp_checker u_mbp_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_red(out_red),
  .out_green(out_green),
  .out_blue(out_blue),
  .read_status(read_status)
);
